### rtl/lbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants of the LSB-first bit packer.
// ----------------------------------------------------------------------------
package lbp_pkg;

   localparam int BYTE_W   = 8;   // bits in one output word
   localparam int PEND_W   = 7;   // most bits that can wait between items
   localparam int CODE_W   = 32;  // bits carried by code_value
   localparam int CLEN_W   = 6;   // bits carried by code_length
   localparam int REQ_W    = 40;  // request tdata, padded to whole bytes

   localparam logic OP_PUT   = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } lbp_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // take the accepted request into the accumulator
      logic emit;   // move the low byte into the output register
   } lbp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic load_full;  // the request on the port completes at least one byte
      logic pend_full;  // the accumulator holds at least one whole byte
      logic last_byte;  // the byte at the bottom is the final one of the item
      logic out_free;   // the output register can take a byte this cycle
   } lbp_sts_type;

endpackage
`default_nettype wire

### rtl/lsb_first_bit_packer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsb_first_bit_packer
// Packs variable-length codes into bytes, least significant bit first.
//
// Request channel (req_): tuser selects put (0) or flush (1); tdata carries
// the code value and its bit count. A put appends the low code_length bits
// (clipped to MAX_CODE_BITS) above the pending bits; a flush sends the
// pending partial byte, zero-padded, and clears it.
// Response channel (rsp_): one packed byte per word, tlast on the final
// byte produced by a request.
// Timing: a request is taken in the idle state; each completed byte is then
// moved to the output register by the drain loop, at most four per item at
// the default width. The first byte is registered after the accumulator has
// taken the request. Requests that complete no byte leave the sequencer idle.
// The drain loop holds when rsp_tready is low and the output register is
// full; req_tready stays low until the last byte of the item is registered,
// and a new request may then enter while that byte still waits.
// Reset clears the pending bits and the output register.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer #(
   parameter int MAX_CODE_BITS = 32
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   output logic                            req_tready,
   input  wire [lbp_pkg::REQ_W-1:0]        req_tdata,   // code_value, code_length
   input  wire                             req_tuser,   // opcode
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [lbp_pkg::BYTE_W-1:0]      rsp_tdata,   // out_byte
   output logic                            rsp_tlast
);

   lbp_pkg::lbp_cmd_type cmd;
   lbp_pkg::lbp_sts_type sts;

   logic [lbp_pkg::CODE_W-1:0] code_value;
   logic [lbp_pkg::CLEN_W-1:0] code_length;

   assign code_value  = req_tdata[lbp_pkg::CODE_W-1:0];
   assign code_length = req_tdata[lbp_pkg::CODE_W +: lbp_pkg::CLEN_W];

   lbp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lbp_datapath #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .opcode      (req_tuser),
      .code_value  (code_value),
      .code_length (code_length),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   a_load_emit_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.emit))
      else $error("load and emit in the same cycle");

   a_emit_whole: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.pend_full)
      else $error("byte emitted without eight pending bits");

   a_idle_partial: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !sts.pend_full)
      else $error("whole byte left behind when taking a request");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_tvalid)
      else $error("emitted byte not presented");

endmodule
`default_nettype wire

### rtl/lbp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_ctrl
// Sequencer of the bit packer: accepts one request, then drains whole bytes.
// ----------------------------------------------------------------------------
module lbp_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  lbp_pkg::lbp_sts_type sts,
   output lbp_pkg::lbp_cmd_type cmd
);

   lbp_pkg::lbp_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         lbp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
            if (req_tvalid && sts.load_full) begin
               state_in = lbp_pkg::ST_EMIT;
            end
         end
         lbp_pkg::ST_EMIT: begin
            // advance one byte whenever the output register has room
            cmd.emit = sts.out_free;
            if (sts.out_free && sts.last_byte) begin
               state_in = lbp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lbp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### rtl/lbp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_datapath
// Bit accumulator, bit counter and output word register of the bit packer.
// ----------------------------------------------------------------------------
module lbp_datapath #(
   parameter int MAX_CODE_BITS = 32
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              opcode,
   input  wire [lbp_pkg::CODE_W-1:0]        code_value,
   input  wire [lbp_pkg::CLEN_W-1:0]        code_length,
   input  lbp_pkg::lbp_cmd_type             cmd,
   output lbp_pkg::lbp_sts_type             sts,
   input  wire                              rsp_tready,
   output logic                             rsp_tvalid,
   output logic [lbp_pkg::BYTE_W-1:0]       rsp_tdata,
   output logic                             rsp_tlast
);

   localparam int ACC_W = MAX_CODE_BITS + lbp_pkg::PEND_W;
   localparam int CNT_W = $clog2(ACC_W + 1);
   localparam int LEN_W = lbp_pkg::CLEN_W + 1;

   logic [ACC_W-1:0]            acc_ff, acc_in;
   logic [CNT_W-1:0]            total_ff, total_in;
   logic                        valid_ff, valid_in;
   logic [lbp_pkg::BYTE_W-1:0]  byte_ff, byte_in;
   logic                        last_ff, last_in;

   logic [LEN_W-1:0]            len_ext;
   logic [LEN_W-1:0]            len_clip;
   logic [CNT_W-1:0]            len_sat;
   logic [lbp_pkg::CODE_W-1:0]  val_masked;
   logic [ACC_W-1:0]            val_shifted;
   logic [CNT_W-1:0]            put_total;
   logic [CNT_W-1:0]            remain;
   logic [2:0]                  pend_cnt;

   assign pend_cnt = total_ff[2:0];
   assign len_ext  = {1'b0, code_length};

   always_comb begin
      // clip overlong codes, then clear bits above the length
      if (len_ext > LEN_W'(MAX_CODE_BITS)) begin
         len_clip = LEN_W'(MAX_CODE_BITS);
      end else begin
         len_clip = len_ext;
      end
      len_sat = CNT_W'(len_clip);
      if (len_clip >= LEN_W'(lbp_pkg::CODE_W)) begin
         val_masked = code_value;
      end else begin
         val_masked = code_value & ~({lbp_pkg::CODE_W{1'b1}} << len_clip[4:0]);
      end
      val_shifted = ACC_W'(val_masked) << pend_cnt;
      put_total   = CNT_W'(pend_cnt) + len_sat;
      remain      = total_ff - CNT_W'(lbp_pkg::BYTE_W);
   end

   always_comb begin
      if (opcode == lbp_pkg::OP_PUT) begin
         sts.load_full = (put_total >= CNT_W'(lbp_pkg::BYTE_W));
      end else begin
         sts.load_full = (pend_cnt != 3'd0);
      end
      sts.pend_full = (total_ff >= CNT_W'(lbp_pkg::BYTE_W));
      sts.last_byte = (remain < CNT_W'(lbp_pkg::BYTE_W));
      sts.out_free  = !valid_ff || rsp_tready;
   end

   always_comb begin
      acc_in   = acc_ff;
      total_in = total_ff;
      valid_in = valid_ff && !rsp_tready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (cmd.load) begin
         if (opcode == lbp_pkg::OP_PUT) begin
            acc_in   = acc_ff | val_shifted;
            total_in = put_total;
         end else if (pend_cnt != 3'd0) begin
            // pending bits above the count are zero: pad to a full word
            total_in = CNT_W'(lbp_pkg::BYTE_W);
         end
      end else if (cmd.emit) begin
         acc_in   = acc_ff >> lbp_pkg::BYTE_W;
         total_in = remain;
         valid_in = 1'b1;
         byte_in  = acc_ff[lbp_pkg::BYTE_W-1:0];
         last_in  = sts.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         total_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         total_ff <= total_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire
